// File: hw/rtl/shdlc_rx_pkg.sv
// shared constants, codes and types of the shdlc frame receiver
`timescale 1ns / 1ps
`default_nettype none

package shdlc_rx_pkg;

  // default payload capacity of one frame buffer
  localparam int MAX_DATA_DEF = 32;

  // line framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] ESC_XON   = 8'h31;
  localparam logic [7:0] ESC_XOFF  = 8'h33;
  localparam logic [7:0] DC1_BYTE  = 8'h11;
  localparam logic [7:0] DC3_BYTE  = 8'h13;
  localparam logic [7:0] INV_MASK  = 8'hFF;

  // frame layout
  localparam int HDR_BYTES   = 4;
  localparam int MIN_CONTENT = 5;
  localparam int COUNT_W     = 7;
  localparam int COUNT_MAX   = 127;

  // result status codes
  localparam logic [2:0] ST_OK  = 3'd0;
  localparam logic [2:0] ST_CHK = 3'd1;
  localparam logic [2:0] ST_DEV = 3'd2;
  localparam logic [2:0] ST_MAL = 3'd3;
  localparam logic [2:0] ST_OVF = 3'd4;

  // closed frames waiting for the emitter (one per frame buffer)
  localparam int QUEUE_DEPTH = 2;

  // summary of one closed frame
  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] device_state;
    logic [7:0] payload_length;
    logic [2:0] status;
    logic       single;
  } frame_desc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD,
    BK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/shdlc_frame_receiver_core.sv
// top level of the shdlc byte-stuffed frame receiver
`timescale 1ns / 1ps
`default_nettype none

// Receives raw serial line bytes on the in_ channel and delivers decoded frame
// results on the out_ channel. A 0x7E flag opens a frame; escape pairs are
// removed, and the address, command, state and length header bytes plus the
// payload and checksum are captured. On the closing flag the frame is judged
// and produces one result per payload byte, or a single result carrying the
// status (checksum, device error, malformed or overflow, or ok for an empty
// payload). Rate: the front takes one line byte per cycle while in_stall is
// low; an unknown escape pair adds a replay step, since the kept 0x7D and the
// following byte each need a write slot in the payload memory. Payload memory
// holds two frame buffers, so the front keeps receiving the next frame while
// the emitter works through the previous one; in_stall rises while both
// buffers are held by closed frames, and while the second byte of an unknown
// escape pair is replayed. The emitter reads the memory through a registered
// port and delivers each payload result through the fetch, load and hold
// states and a single status result through the idle and hold states, as
// long as the output does not stall. No clearing pass follows reset.

module shdlc_frame_receiver_core #(
  parameter int MAX_DATA = shdlc_rx_pkg::MAX_DATA_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_address,
  output logic [7:0]      out_command,
  output logic [7:0]      out_device_state,
  output logic [7:0]      out_payload_length,
  output logic [7:0]      out_data_byte,
  output logic [5:0]      out_byte_index,
  output logic            out_last,
  output logic [2:0]      out_status
);

  // payload index width covers the checksum slot after MAX_DATA bytes
  localparam int IDX_W = $clog2(MAX_DATA + 1);

  // closed frame handoff
  logic                      q_full;
  logic                      q_empty;
  logic                      push;
  logic                      pop;
  shdlc_rx_pkg::frame_desc_t push_desc;
  shdlc_rx_pkg::frame_desc_t q_head;

  // payload write request from the front
  logic                      mem_we;
  logic                      mem_bank;
  logic [IDX_W-1:0]          mem_idx;
  logic [7:0]                mem_data;

  // unstuffing, header capture and frame judgement
  shdlc_rx_front #(
    .MAX_DATA (MAX_DATA),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc),
    .mem_we     (mem_we),
    .mem_bank   (mem_bank),
    .mem_idx    (mem_idx),
    .mem_data   (mem_data)
  );

  // one entry per frame buffer
  shdlc_rx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .q_head    (q_head)
  );

  // payload buffers and result sequencing
  shdlc_rx_back #(
    .MAX_DATA (MAX_DATA),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .pop                (pop),
    .mem_we             (mem_we),
    .mem_bank           (mem_bank),
    .mem_idx            (mem_idx),
    .mem_data           (mem_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_address        (out_address),
    .out_command        (out_command),
    .out_device_state   (out_device_state),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

// File: hw/rtl/shdlc_rx_front.sv
// byte unstuffing, header capture, checksum and frame close classification
`timescale 1ns / 1ps
`default_nettype none

module shdlc_rx_front #(
  parameter int MAX_DATA = shdlc_rx_pkg::MAX_DATA_DEF,
  parameter int IDX_W    = $clog2(MAX_DATA + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_rx_byte,
  input  wire logic                      q_full,
  output logic                           push,
  output shdlc_rx_pkg::frame_desc_t      push_desc,
  output logic                           mem_we,
  output logic                           mem_bank,
  output logic [IDX_W-1:0]               mem_idx,
  output logic [7:0]                     mem_data
);

  localparam int CW = shdlc_rx_pkg::COUNT_W;
  localparam logic [CW-1:0] MAXD = CW'(MAX_DATA);

  logic          in_frame_r, in_frame_nxt;
  logic          esc_r, esc_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    last_r, last_nxt;
  logic [7:0]    hdr_addr_r, hdr_addr_nxt;
  logic [7:0]    hdr_cmd_r, hdr_cmd_nxt;
  logic [7:0]    hdr_state_r, hdr_state_nxt;
  logic [7:0]    hdr_len_r, hdr_len_nxt;
  logic          replay_r, replay_nxt;
  logic [7:0]    replay_byte_r, replay_byte_nxt;
  logic          wr_bank_r, wr_bank_nxt;

  logic          step;
  logic [7:0]    cur_byte;
  logic          take_en;
  logic [7:0]    take_byte;
  logic          do_close;
  logic          do_clear;
  logic [CW-1:0] pay_off;
  logic [CW-1:0] cnt_m5;
  logic [7:0]    chk_diff;
  logic [2:0]    close_status;

  // a pending split escape replays its second byte before new input
  assign in_stall = q_full | replay_r;
  assign step     = !q_full && (replay_r || in_valid);
  assign cur_byte = replay_r ? replay_byte_r : in_rx_byte;

  assign pay_off  = count_r - CW'(shdlc_rx_pkg::HDR_BYTES);
  assign cnt_m5   = count_r - CW'(shdlc_rx_pkg::MIN_CONTENT);
  // the last content byte is the checksum
  assign chk_diff = sum_r - last_r;

  always_comb begin
    if (ovf_r) begin
      close_status = shdlc_rx_pkg::ST_OVF;
    end else if (count_r < CW'(shdlc_rx_pkg::MIN_CONTENT)) begin
      close_status = shdlc_rx_pkg::ST_MAL;
    end else if ((chk_diff ^ shdlc_rx_pkg::INV_MASK) != last_r) begin
      close_status = shdlc_rx_pkg::ST_CHK;
    end else if (hdr_len_r != 8'(cnt_m5)) begin
      close_status = shdlc_rx_pkg::ST_MAL;
    end else if (hdr_state_r != 8'd0) begin
      close_status = shdlc_rx_pkg::ST_DEV;
    end else begin
      close_status = shdlc_rx_pkg::ST_OK;
    end
  end

  always_comb begin
    push_desc.address        = hdr_addr_r;
    push_desc.command        = hdr_cmd_r;
    push_desc.device_state   = hdr_state_r;
    push_desc.payload_length = hdr_len_r;
    push_desc.status         = close_status;
    push_desc.single         = (close_status != shdlc_rx_pkg::ST_OK) || (hdr_len_r == 8'd0);
  end

  // byte classification
  always_comb begin
    take_en         = 1'b0;
    take_byte       = 8'd0;
    do_close        = 1'b0;
    do_clear        = 1'b0;
    in_frame_nxt    = in_frame_r;
    esc_nxt         = esc_r;
    replay_nxt      = replay_r;
    replay_byte_nxt = replay_byte_r;
    if (step) begin
      replay_nxt = 1'b0;
      if (!in_frame_r) begin
        if (cur_byte == shdlc_rx_pkg::FLAG_BYTE) begin
          in_frame_nxt = 1'b1;
          do_clear     = 1'b1;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        take_en = 1'b1;
        case (cur_byte)
          shdlc_rx_pkg::ESC_FLAG: take_byte = shdlc_rx_pkg::FLAG_BYTE;
          shdlc_rx_pkg::ESC_ESC:  take_byte = shdlc_rx_pkg::ESC_BYTE;
          shdlc_rx_pkg::ESC_XON:  take_byte = shdlc_rx_pkg::DC1_BYTE;
          shdlc_rx_pkg::ESC_XOFF: take_byte = shdlc_rx_pkg::DC3_BYTE;
          default: begin
            // keep the escape and handle this byte in a replay step
            take_byte       = shdlc_rx_pkg::ESC_BYTE;
            replay_nxt      = 1'b1;
            replay_byte_nxt = cur_byte;
          end
        endcase
      end else if (cur_byte == shdlc_rx_pkg::FLAG_BYTE) begin
        do_clear = 1'b1;
        do_close = (count_r != '0);
      end else if (cur_byte == shdlc_rx_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        take_en   = 1'b1;
        take_byte = cur_byte;
      end
    end
  end

  // content capture
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    hdr_addr_nxt  = hdr_addr_r;
    hdr_cmd_nxt   = hdr_cmd_r;
    hdr_state_nxt = hdr_state_r;
    hdr_len_nxt   = hdr_len_r;
    wr_bank_nxt   = wr_bank_r;
    mem_we        = 1'b0;
    mem_bank      = wr_bank_r;
    mem_idx       = pay_off[IDX_W-1:0];
    mem_data      = take_byte;
    push          = do_close;
    if (take_en) begin
      if (count_r < CW'(shdlc_rx_pkg::HDR_BYTES)) begin
        case (count_r[1:0])
          2'd0:    hdr_addr_nxt  = take_byte;
          2'd1:    hdr_cmd_nxt   = take_byte;
          2'd2:    hdr_state_nxt = take_byte;
          default: hdr_len_nxt   = take_byte;
        endcase
      end else if (pay_off <= MAXD) begin
        mem_we = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      sum_nxt  = sum_r + take_byte;
      last_nxt = take_byte;
      if (count_r != CW'(shdlc_rx_pkg::COUNT_MAX)) begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (do_close) begin
      wr_bank_nxt = ~wr_bank_r;
    end
    if (do_clear) begin
      count_nxt     = '0;
      ovf_nxt       = 1'b0;
      sum_nxt       = 8'd0;
      hdr_addr_nxt  = 8'd0;
      hdr_cmd_nxt   = 8'd0;
      hdr_state_nxt = 8'd0;
      hdr_len_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sum_r       <= 8'd0;
      hdr_addr_r  <= 8'd0;
      hdr_cmd_r   <= 8'd0;
      hdr_state_r <= 8'd0;
      hdr_len_r   <= 8'd0;
      replay_r    <= 1'b0;
      wr_bank_r   <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sum_r       <= sum_nxt;
      hdr_addr_r  <= hdr_addr_nxt;
      hdr_cmd_r   <= hdr_cmd_nxt;
      hdr_state_r <= hdr_state_nxt;
      hdr_len_r   <= hdr_len_nxt;
      replay_r    <= replay_nxt;
      wr_bank_r   <= wr_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r        <= last_nxt;
    replay_byte_r <= replay_byte_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/shdlc_rx_queue.sv
// short queue of closed frame summaries between front and emitter
`timescale 1ns / 1ps
`default_nettype none

module shdlc_rx_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire shdlc_rx_pkg::frame_desc_t push_desc,
  input  wire logic                      pop,
  output logic                           q_full,
  output logic                           q_empty,
  output shdlc_rx_pkg::frame_desc_t      q_head
);

  localparam int DEPTH = shdlc_rx_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  shdlc_rx_pkg::frame_desc_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;

  assign q_full  = (fill_r == (PTR_W+1)'(DEPTH));
  assign q_empty = (fill_r == '0);
  assign q_head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shdlc_rx_back.sv
// double-buffered payload memory and result emitter
`timescale 1ns / 1ps
`default_nettype none

module shdlc_rx_back #(
  parameter int MAX_DATA = shdlc_rx_pkg::MAX_DATA_DEF,
  parameter int IDX_W    = $clog2(MAX_DATA + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_empty,
  input  wire shdlc_rx_pkg::frame_desc_t q_head,
  output logic                           pop,
  input  wire logic                      mem_we,
  input  wire logic                      mem_bank,
  input  wire logic [IDX_W-1:0]          mem_idx,
  input  wire logic [7:0]                mem_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_address,
  output logic [7:0]                     out_command,
  output logic [7:0]                     out_device_state,
  output logic [7:0]                     out_payload_length,
  output logic [7:0]                     out_data_byte,
  output logic [5:0]                     out_byte_index,
  output logic                           out_last,
  output logic [2:0]                     out_status
);

  localparam int DEPTH = MAX_DATA + 1;

  logic [7:0] pay_mem [2][DEPTH];
  logic [7:0] rd_data_r;

  shdlc_rx_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_bank_r, rd_bank_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_take;
  logic             ld_single, ld_data, idx_clr, idx_inc;

  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shdlc_rx_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.single ? shdlc_rx_pkg::BK_HOLD : shdlc_rx_pkg::BK_FETCH;
        end
      end
      shdlc_rx_pkg::BK_FETCH: state_nxt = shdlc_rx_pkg::BK_LOAD;
      shdlc_rx_pkg::BK_LOAD:  state_nxt = shdlc_rx_pkg::BK_HOLD;
      shdlc_rx_pkg::BK_HOLD: begin
        if (out_take) begin
          state_nxt = out_last ? shdlc_rx_pkg::BK_IDLE : shdlc_rx_pkg::BK_FETCH;
        end
      end
      default: state_nxt = shdlc_rx_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ld_single = 1'b0;
    ld_data   = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    pop       = 1'b0;
    case (state_r)
      shdlc_rx_pkg::BK_IDLE: begin
        if (!q_empty) begin
          ld_single = q_head.single;
          idx_clr   = !q_head.single;
        end
      end
      shdlc_rx_pkg::BK_LOAD: ld_data = 1'b1;
      shdlc_rx_pkg::BK_HOLD: begin
        pop     = out_take && out_last;
        idx_inc = out_take && !out_last;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    rd_bank_nxt   = rd_bank_r;
    out_valid_nxt = out_valid_r;
    if (idx_clr) begin
      idx_nxt = '0;
    end else if (idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (pop) begin
      rd_bank_nxt = ~rd_bank_r;
    end
    if (ld_single || ld_data) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shdlc_rx_pkg::BK_IDLE;
      idx_r       <= '0;
      rd_bank_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_bank_r   <= rd_bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload memory: front writes one bank while this side reads the other
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[mem_bank][mem_idx] <= mem_data;
    end
    rd_data_r <= pay_mem[rd_bank_r][idx_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld_single || ld_data) begin
      out_address        <= q_head.address;
      out_command        <= q_head.command;
      out_device_state   <= q_head.device_state;
      out_payload_length <= q_head.payload_length;
    end
    if (ld_single) begin
      out_data_byte  <= 8'd0;
      out_byte_index <= 6'd0;
      out_last       <= 1'b1;
      out_status     <= q_head.status;
    end else if (ld_data) begin
      out_data_byte  <= rd_data_r;
      out_byte_index <= 6'(idx_r);
      out_last       <= ((8'(idx_r) + 8'd1) == q_head.payload_length);
      out_status     <= shdlc_rx_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: tb/shdlc_frame_receiver_checker.sv
// checker for the shdlc frame receiver: predicts results from accepted line bytes and compares
`timescale 1ns / 1ps

module shdlc_frame_receiver_checker #(
  parameter int MAX_DATA = shdlc_rx_pkg::MAX_DATA_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_address,
  input  wire logic [7:0] out_command,
  input  wire logic [7:0] out_device_state,
  input  wire logic [7:0] out_payload_length,
  input  wire logic [7:0] out_data_byte,
  input  wire logic [5:0] out_byte_index,
  input  wire logic       out_last,
  input  wire logic [2:0] out_status,
  output int              mismatches,
  output int              pending,
  output int              results_seen
);

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] device_state;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;
    logic [2:0] status;
  } rx_result_t;

  // decoder state
  logic       framing_active;
  logic       esc_held;
  logic       overrun;
  int         n_content;
  logic [7:0] acc_sum;
  logic [7:0] hdr_addr;
  logic [7:0] hdr_cmd;
  logic [7:0] hdr_state;
  logic [7:0] hdr_len;
  logic [7:0] body_buf [0:MAX_DATA];

  rx_result_t expected_q [$];

  function automatic void clear_frame_state();
    esc_held  = 1'b0;
    n_content = 0;
    overrun   = 1'b0;
    acc_sum   = 8'h00;
    hdr_addr  = 8'h00;
    hdr_cmd   = 8'h00;
    hdr_state = 8'h00;
    hdr_len   = 8'h00;
  endfunction

  function automatic void absorb_content(input logic [7:0] b);
    int p;
    p = n_content;
    if (p == 0) hdr_addr = b;
    else if (p == 1) hdr_cmd = b;
    else if (p == 2) hdr_state = b;
    else if (p == 3) hdr_len = b;
    else if (p - shdlc_rx_pkg::HDR_BYTES <= MAX_DATA)
      body_buf[p - shdlc_rx_pkg::HDR_BYTES] = b;
    else overrun = 1'b1;
    acc_sum = acc_sum + b;
    if (n_content < shdlc_rx_pkg::COUNT_MAX) n_content++;
  endfunction

  function automatic void push_result(input logic [7:0] data, input int idx,
                                      input logic last, input logic [2:0] st);
    rx_result_t r;
    r.address        = hdr_addr;
    r.command        = hdr_cmd;
    r.device_state   = hdr_state;
    r.payload_length = hdr_len;
    r.data_byte      = data;
    r.byte_index     = 6'(idx);
    r.last           = last;
    r.status         = st;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // byte outside an escape pair: flag, escape lead-in or content
  function automatic void plain_byte(input logic [7:0] b);
    logic [2:0] st;
    logic [7:0] chk;
    logic [7:0] rest;
    if (b == shdlc_rx_pkg::FLAG_BYTE) begin
      if (n_content != 0) begin
        st = shdlc_rx_pkg::ST_OK;
        if (overrun) begin
          st = shdlc_rx_pkg::ST_OVF;
        end else if (n_content < shdlc_rx_pkg::MIN_CONTENT) begin
          st = shdlc_rx_pkg::ST_MAL;
        end else begin
          chk  = body_buf[n_content - shdlc_rx_pkg::MIN_CONTENT];
          rest = acc_sum - chk;
          if ((rest ^ shdlc_rx_pkg::INV_MASK) != chk) st = shdlc_rx_pkg::ST_CHK;
          else if (int'(hdr_len) != n_content - shdlc_rx_pkg::MIN_CONTENT)
            st = shdlc_rx_pkg::ST_MAL;
          else if (hdr_state != 8'h00) st = shdlc_rx_pkg::ST_DEV;
        end
        if (st != shdlc_rx_pkg::ST_OK || hdr_len == 8'h00) begin
          push_result(8'h00, 0, 1'b1, st);
        end else begin
          for (int i = 0; i < int'(hdr_len); i++)
            push_result(body_buf[i], i, (i + 1 == int'(hdr_len)), shdlc_rx_pkg::ST_OK);
        end
      end
      clear_frame_state();
    end else if (b == shdlc_rx_pkg::ESC_BYTE) begin
      esc_held = 1'b1;
    end else begin
      absorb_content(b);
    end
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    if (!framing_active) begin
      if (b == shdlc_rx_pkg::FLAG_BYTE) begin
        framing_active = 1'b1;
        clear_frame_state();
      end
    end else if (esc_held) begin
      esc_held = 1'b0;
      case (b)
        shdlc_rx_pkg::ESC_FLAG: absorb_content(shdlc_rx_pkg::FLAG_BYTE);
        shdlc_rx_pkg::ESC_ESC:  absorb_content(shdlc_rx_pkg::ESC_BYTE);
        shdlc_rx_pkg::ESC_XON:  absorb_content(shdlc_rx_pkg::DC1_BYTE);
        shdlc_rx_pkg::ESC_XOFF: absorb_content(shdlc_rx_pkg::DC3_BYTE);
        default: begin
          // unknown pair: the 0x7D stays, the byte is taken on its own
          absorb_content(shdlc_rx_pkg::ESC_BYTE);
          plain_byte(b);
        end
      endcase
    end else begin
      plain_byte(b);
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst_n) begin
      framing_active = 1'b0;
      clear_frame_state();
      foreach (body_buf[i]) body_buf[i] = 8'h00;
      expected_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: data 0x%0h status %0d",
                 out_data_byte, out_status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("address", want.address, out_address);
          check_field("command", want.command, out_command);
          check_field("device_state", want.device_state, out_device_state);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("byte_index", 8'(want.byte_index), 8'(out_byte_index));
          check_field("last", 8'(want.last), 8'(out_last));
          check_field("status", 8'(want.status), 8'(out_status));
        end
      end
      if (in_valid && !in_stall) decode_rx_byte(in_rx_byte);
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/shdlc_frame_receiver_core_test.sv
// testbench top for the shdlc frame receiver core: clock, reset, line stimulus and verdict
`timescale 1ns / 1ps

module shdlc_frame_receiver_core_test;

  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 400;   // opening sequence plus random frames, at least 400 bytes
  localparam int PHASE1_AT      = 160;
  localparam int PHASE2_AT      = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;

  // how one generated frame goes wrong, if at all
  typedef enum int {
    FK_GOOD,
    FK_BAD_SUM,
    FK_BAD_LEN,
    FK_DEVICE,
    FK_SHORT,
    FK_BAD_ESC,
    FK_NOISE,
    FK_OVERFLOW
  } frame_kind_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b1;
  logic [7:0] out_address;
  logic [7:0] out_command;
  logic [7:0] out_device_state;
  logic [7:0] out_payload_length;
  logic [7:0] out_data_byte;
  logic [5:0] out_byte_index;
  logic       out_last;
  logic [2:0] out_status;

  // idle mix: the sender's share is used by the sending tasks, the receiver's by its process
  int   tx_idle_pct = 24;
  int   rx_idle_pct = 87;
  logic hold_req    = 1'b0;
  logic hold_used   = 1'b0;
  int   hold_left   = 0;

  int bytes_sent   = 0;
  int frames_sent  = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;
  int results_seen;

  logic [7:0] frame_bytes [$];

  shdlc_frame_receiver_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_address        (out_address),
    .out_command        (out_command),
    .out_device_state   (out_device_state),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .out_status         (out_status)
  );

  shdlc_frame_receiver_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_address        (out_address),
    .out_command        (out_command),
    .out_device_state   (out_device_state),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .out_status         (out_status),
    .mismatches         (mismatches),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stall at the current mix, plus one long hold-off once it is requested;
  // during the hold-off the sender keeps going, so both frame buffers fill and in_stall rises
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog: too long without any request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // line byte with a bias toward the framing and flow-control values
  function automatic logic [7:0] rand_line_byte();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(11))
      0: return shdlc_rx_pkg::FLAG_BYTE;
      1: return shdlc_rx_pkg::ESC_BYTE;
      2: return shdlc_rx_pkg::DC1_BYTE;
      3: return shdlc_rx_pkg::DC3_BYTE;
      4: return 8'h00;
      5: return 8'hFF;
      default: return r[7:0];
    endcase
  endfunction

  // offer one line byte, idling first at the sender's rate; returns once the request is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // byte-stuff frame_bytes onto the line and close with a flag; optionally slip in one
  // unknown escape pair, which leaves a stray 0x7D in the content
  task automatic send_content(input logic inject);
    int         cut;
    logic [7:0] odd;
    logic [7:0] b;
    cut = -1;
    if (inject) cut = $urandom_range(frame_bytes.size() - 1);
    foreach (frame_bytes[i]) begin
      b = frame_bytes[i];
      if (i == cut) begin
        odd = rand_line_byte();
        while (odd == shdlc_rx_pkg::ESC_FLAG || odd == shdlc_rx_pkg::ESC_ESC ||
               odd == shdlc_rx_pkg::ESC_XON || odd == shdlc_rx_pkg::ESC_XOFF)
          odd = rand_line_byte();
        send_byte(shdlc_rx_pkg::ESC_BYTE);
        send_byte(odd);
      end
      if (b == shdlc_rx_pkg::FLAG_BYTE) begin
        send_byte(shdlc_rx_pkg::ESC_BYTE);
        send_byte(shdlc_rx_pkg::ESC_FLAG);
      end else if (b == shdlc_rx_pkg::ESC_BYTE) begin
        send_byte(shdlc_rx_pkg::ESC_BYTE);
        send_byte(shdlc_rx_pkg::ESC_ESC);
      end else if (b == shdlc_rx_pkg::DC1_BYTE && $urandom_range(1) == 1) begin
        send_byte(shdlc_rx_pkg::ESC_BYTE);
        send_byte(shdlc_rx_pkg::ESC_XON);
      end else if (b == shdlc_rx_pkg::DC3_BYTE && $urandom_range(1) == 1) begin
        send_byte(shdlc_rx_pkg::ESC_BYTE);
        send_byte(shdlc_rx_pkg::ESC_XOFF);
      end else begin
        send_byte(b);
      end
    end
    send_byte(shdlc_rx_pkg::FLAG_BYTE);
  endtask

  // build one frame of the given kind with random content and put it on the line
  task automatic run_frame(input frame_kind_t kind, input int n_pay);
    logic [7:0] acc;
    logic [7:0] state_byte;
    logic [7:0] len_field;
    int         n_raw;
    frame_bytes.delete();
    // now and then a repeated flag ahead of the frame
    if ($urandom_range(9) == 0) send_byte(shdlc_rx_pkg::FLAG_BYTE);
    if (kind == FK_NOISE) begin
      // raw garbage, flags and escapes included, not stuffed
      n_raw = $urandom_range(12, 1);
      repeat (n_raw) send_byte(rand_line_byte());
      send_byte(shdlc_rx_pkg::FLAG_BYTE);
    end else if (kind == FK_SHORT) begin
      n_raw = $urandom_range(shdlc_rx_pkg::MIN_CONTENT - 1, 1);
      repeat (n_raw) frame_bytes.insert(frame_bytes.size(), rand_line_byte());
      send_content(1'b0);
    end else begin
      state_byte = 8'h00;
      if (kind == FK_DEVICE) state_byte = 8'($urandom_range(255, 1));
      len_field = 8'(n_pay);
      if (kind == FK_BAD_LEN) len_field = len_field + 8'($urandom_range(255, 1));
      frame_bytes.insert(frame_bytes.size(), rand_line_byte());
      frame_bytes.insert(frame_bytes.size(), rand_line_byte());
      frame_bytes.insert(frame_bytes.size(), state_byte);
      frame_bytes.insert(frame_bytes.size(), len_field);
      repeat (n_pay) frame_bytes.insert(frame_bytes.size(), rand_line_byte());
      acc = 8'h00;
      foreach (frame_bytes[i]) acc = acc + frame_bytes[i];
      acc = acc ^ shdlc_rx_pkg::INV_MASK;
      if (kind == FK_BAD_SUM) acc = acc ^ 8'($urandom_range(255, 1));
      frame_bytes.insert(frame_bytes.size(), acc);
      send_content(kind == FK_BAD_ESC);
    end
    frames_sent++;
  endtask

  initial begin
    frame_kind_t kind;
    int          pick;
    int          n_pay;
    int          phase;

    phase = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // opening sequence:
    //  idle bytes outside a frame, ignored
    //  opening flag, then a repeated flag that only resyncs
    //  unknown escape pair in a frame that is too short
    //  escape right before the flag: 0x7D kept, frame closes short
    //  good frame with an empty payload, all-ones address
    //  good one-byte frame with the 7D5D, 7D31 and 7D5E pairs
    frame_bytes = '{8'h00, 8'hFF, shdlc_rx_pkg::ESC_BYTE, shdlc_rx_pkg::ESC_FLAG,
                    shdlc_rx_pkg::FLAG_BYTE, shdlc_rx_pkg::FLAG_BYTE,
                    shdlc_rx_pkg::ESC_BYTE, 8'h41, shdlc_rx_pkg::FLAG_BYTE,
                    shdlc_rx_pkg::ESC_BYTE, shdlc_rx_pkg::FLAG_BYTE,
                    8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, shdlc_rx_pkg::FLAG_BYTE,
                    shdlc_rx_pkg::ESC_BYTE, shdlc_rx_pkg::ESC_ESC,
                    shdlc_rx_pkg::ESC_BYTE, shdlc_rx_pkg::ESC_XON, 8'h00, 8'h01,
                    shdlc_rx_pkg::ESC_BYTE, shdlc_rx_pkg::ESC_FLAG, 8'hF2,
                    shdlc_rx_pkg::FLAG_BYTE};
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);

    // random frames, good ones the largest share; the first two are the largest good payload and
    // an overflow, the rest mostly small
    while (bytes_sent < ITEM_TARGET) begin
      if (phase == 0 && bytes_sent >= PHASE1_AT) begin
        phase = 1;
        tx_idle_pct = 87;
        rx_idle_pct <= 24;
      end else if (phase == 1 && bytes_sent >= PHASE2_AT) begin
        phase = 2;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
      end
      pick  = $urandom_range(99);
      n_pay = ($urandom_range(9) == 0) ? $urandom_range(shdlc_rx_pkg::MAX_DATA_DEF, 7)
                                       : $urandom_range(6);
      if (frames_sent == 0) begin
        kind  = FK_GOOD;
        n_pay = shdlc_rx_pkg::MAX_DATA_DEF;
      end else if (frames_sent == 1 || pick >= 94) begin
        kind  = FK_OVERFLOW;
        n_pay = $urandom_range(shdlc_rx_pkg::MAX_DATA_DEF + 4, shdlc_rx_pkg::MAX_DATA_DEF + 1);
      end else if (pick < 45) kind = FK_GOOD;
      else if (pick < 55) kind = FK_BAD_SUM;
      else if (pick < 63) kind = FK_BAD_LEN;
      else if (pick < 71) kind = FK_DEVICE;
      else if (pick < 76) kind = FK_SHORT;
      else if (pick < 86) kind = FK_BAD_ESC;
      else kind = FK_NOISE;
      run_frame(kind, n_pay);
    end
    in_valid <= 1'b0;

    // let the checker catch up, then a quiet stretch to catch stray results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d line bytes in %0d generated frames, %0d results compared",
             bytes_sent, frames_sent, results_seen);
    $display("idle mixes: sender light and receiver heavy, reversed, none; one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/shdlc_rx_pkg.sv
hw/rtl/shdlc_rx_front.sv
hw/rtl/shdlc_rx_queue.sv
hw/rtl/shdlc_rx_back.sv
hw/rtl/shdlc_frame_receiver_core.sv
tb/shdlc_frame_receiver_checker.sv
tb/shdlc_frame_receiver_core_test.sv
